// File: src/iirdf2t_pkg.sv
// Shared constants, item types, state codes and helpers of the DF-II transposed IIR filter.
`default_nettype none

package iirdf2t_pkg;

  // Filter order; the datapath keeps two delay words, so the order in use is clamped to 1..2.
  localparam int ORDER     = 2;
  localparam int EFF_ORDER = (ORDER < 1) ? 1 : ((ORDER > 2) ? 2 : ORDER);

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int DELAY_W    = 40;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = DELAY_W + 2;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = SAMPLE_W / DIGIT_W;
  localparam int DCNT_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int NUM_REGS   = 5;
  localparam int REG_IDX_W  = 3;
  localparam int STEP_W     = 3;
  localparam int FRAC_SHIFT = 14;
  localparam int ROUND_W    = ACC_W - FRAC_SHIFT;

  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (FRAC_SHIFT - 1);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [DELAY_W-1:0]  DELAY_MAX  = {1'b0, {(DELAY_W-1){1'b1}}};
  localparam logic signed [DELAY_W-1:0]  DELAY_MIN  = {1'b1, {(DELAY_W-1){1'b0}}};

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd4;

  localparam logic signed [COEF_W-1:0] COEF_B0_RST = 18'sd16384;

  // Product steps of one item, in the order the sequencer runs them.
  localparam logic [STEP_W-1:0] STEP_B0X = 3'd0;
  localparam logic [STEP_W-1:0] STEP_B1X = 3'd1;
  localparam logic [STEP_W-1:0] STEP_A1Y = 3'd2;
  localparam logic [STEP_W-1:0] STEP_B2X = 3'd3;
  localparam logic [STEP_W-1:0] STEP_A2Y = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROUND,
    ST_SAT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       start_block;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;
    logic signed [DELAY_W-1:0]  delay_first;
    logic signed [DELAY_W-1:0]  delay_second;
  } out_item_t;

  typedef struct packed {
    logic                       start;
    logic signed [COEF_W-1:0]   coef;
    logic signed [SAMPLE_W-1:0] operand;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] product;
  } mul_rsp_t;

  // Coefficient register used by each product step.
  function automatic logic [REG_IDX_W-1:0] coef_of_step(input logic [STEP_W-1:0] step);
    logic [REG_IDX_W-1:0] idx;
    unique case (step)
      STEP_B0X: idx = REG_B0;
      STEP_B1X: idx = REG_B1;
      STEP_A1Y: idx = REG_A1;
      STEP_B2X: idx = REG_B2;
      STEP_A2Y: idx = REG_A2;
      default:  idx = REG_B0;
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

// File: src/iirdf2t_dsmul.sv
// Digit-serial signed multiplier: coefficient times sample, one radix-16 digit per cycle.
`default_nettype none

module iirdf2t_dsmul (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire iirdf2t_pkg::mul_req_t req_i,
  output iirdf2t_pkg::mul_rsp_t      rsp_o
);

  localparam int PP_W = iirdf2t_pkg::COEF_W + iirdf2t_pkg::DIGIT_W + 1;
  localparam int HI_W = PP_W - iirdf2t_pkg::DIGIT_W;
  localparam int DW   = iirdf2t_pkg::DIGIT_W;
  localparam int SW   = iirdf2t_pkg::SAMPLE_W;

  logic                                    busy_q;
  logic                                    done_q;
  logic [iirdf2t_pkg::DCNT_W-1:0]          cnt_q;
  logic signed [iirdf2t_pkg::COEF_W-1:0]   coef_q;
  logic [SW-1:0]                           opnd_q;
  logic signed [HI_W-1:0]                  hi_q;
  logic [SW-1:0]                           lo_q;

  logic                   last;
  logic signed [DW:0]     digit;
  logic signed [PP_W-1:0] pp;
  logic signed [PP_W-1:0] hi_ext;
  logic signed [PP_W-1:0] sum;
  logic [HI_W+SW-1:0]     full;

  // Lower digits are unsigned, the top digit carries the sign of the sample.
  assign last   = (cnt_q == iirdf2t_pkg::DCNT_W'(iirdf2t_pkg::NUM_DIGITS - 1));
  assign digit  = last ? $signed({opnd_q[DW-1], opnd_q[DW-1:0]})
                       : $signed({1'b0, opnd_q[DW-1:0]});
  assign pp     = coef_q * digit;
  assign hi_ext = $signed({{DW{hi_q[HI_W-1]}}, hi_q});
  assign sum    = hi_ext + pp;
  assign full   = {hi_q, lo_q};

  assign rsp_o.done    = done_q;
  assign rsp_o.product = $signed(full[iirdf2t_pkg::PROD_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // The low digits of each partial sum shift out into lo_q as the operand shifts down.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      coef_q <= req_i.coef;
      opnd_q <= req_i.operand;
      hi_q   <= '0;
    end else if (busy_q) begin
      hi_q   <= sum[PP_W-1:DW];
      lo_q   <= {sum[DW-1:0], lo_q[SW-1:DW]};
      opnd_q <= opnd_q >> DW;
    end
  end

endmodule

`default_nettype wire

// File: src/iir_filter_df2t.sv
// One item is processed at a time, so the input is ready again only once the result has
// been registered. The time per item is set by the shared digit-serial multiplier, which
// forms the 2*ORDER+1 products one after another.
// Reset is asynchronous and active low: it clears the delay words, the control state and
// the output valid, and returns the coefficients to b0 = 1.0 and all others zero.
`default_nettype none

module iir_filter_df2t (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire iirdf2t_pkg::in_item_t                  in_item_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output iirdf2t_pkg::out_item_t                      out_item_o,
  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic [iirdf2t_pkg::REG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [iirdf2t_pkg::COEF_W-1:0]         cfg_data_i
);

  localparam int ACC_W   = iirdf2t_pkg::ACC_W;
  localparam int DELAY_W = iirdf2t_pkg::DELAY_W;
  localparam int SW      = iirdf2t_pkg::SAMPLE_W;
  localparam int RW      = iirdf2t_pkg::ROUND_W;

  localparam logic [ACC_W-1:0] ROUND_BIAS_EXT = iirdf2t_pkg::ROUND_BIAS;

  iirdf2t_pkg::state_e state_q, state_d;
  logic [iirdf2t_pkg::STEP_W-1:0] step_q, step_d;

  logic signed [iirdf2t_pkg::COEF_W-1:0] coef_q [iirdf2t_pkg::NUM_REGS];
  logic signed [DELAY_W-1:0]             dly_q  [2];
  logic signed [SW-1:0]                  x_q;
  logic signed [SW-1:0]                  y_q;
  logic                                  clip_q;
  logic signed [ACC_W-1:0]               acc_q;
  iirdf2t_pkg::out_item_t                out_q;
  logic                                  out_valid_q;

  logic                     in_fire;
  logic                     mul_start;
  logic                     load_out;
  iirdf2t_pkg::mul_req_t    mul_req;
  iirdf2t_pkg::mul_rsp_t    mul_rsp;
  logic                     op_is_y;

  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  dly0_ext;
  logic signed [ACC_W-1:0]  dly1_ext;
  logic signed [ACC_W-1:0]  acc_d;
  logic [ACC_W-1:0]         rnd;
  logic [RW-1:0]            y_wide;
  logic                     y_fits;
  logic signed [SW-1:0]     y_sat;
  logic                     acc_fits;
  logic signed [DELAY_W-1:0] dly_sat;

  // ---------------------------------------------------------------------------------------
  // Configuration: a write can always be taken, and the user must write only while the filter
  // is idle; the block does not enforce it. Indexes beyond the five coefficients are dropped.
  // ---------------------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[iirdf2t_pkg::REG_B0] <= iirdf2t_pkg::COEF_B0_RST;
      coef_q[iirdf2t_pkg::REG_B1] <= '0;
      coef_q[iirdf2t_pkg::REG_B2] <= '0;
      coef_q[iirdf2t_pkg::REG_A1] <= '0;
      coef_q[iirdf2t_pkg::REG_A2] <= '0;
    end else if (cfg_valid_i && (cfg_index_i < iirdf2t_pkg::REG_IDX_W'(iirdf2t_pkg::NUM_REGS))) begin
      coef_q[cfg_index_i] <= $signed(cfg_data_i);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sequencer. Each item runs the products in a fixed order:
  //   b0*x  -> acc = s0 + b0*x, then the round state forms the saturated output y;
  //   b1*x  -> acc = s1 + b1*x (s1 only when the order is two);
  //   a1*y  -> acc = acc - a1*y, then the saturate state writes the new s0;
  //   b2*x, a2*y in the same way for the new s1 when the order is two.
  // The old s0 is used only by the first product and the old s1 only by the second, so the
  // new words are written straight back into the delay registers.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      iirdf2t_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = iirdf2t_pkg::ST_MUL;
          step_d  = iirdf2t_pkg::STEP_B0X;
        end
      end
      iirdf2t_pkg::ST_MUL: begin
        if (mul_rsp.done) begin
          unique case (step_q)
            iirdf2t_pkg::STEP_B0X: state_d = iirdf2t_pkg::ST_ROUND;
            iirdf2t_pkg::STEP_B1X: step_d  = iirdf2t_pkg::STEP_A1Y;
            iirdf2t_pkg::STEP_A1Y: state_d = iirdf2t_pkg::ST_SAT;
            iirdf2t_pkg::STEP_B2X: step_d  = iirdf2t_pkg::STEP_A2Y;
            iirdf2t_pkg::STEP_A2Y: state_d = iirdf2t_pkg::ST_SAT;
            default:               state_d = iirdf2t_pkg::ST_SAT;
          endcase
        end
      end
      iirdf2t_pkg::ST_ROUND: begin
        state_d = iirdf2t_pkg::ST_MUL;
        step_d  = iirdf2t_pkg::STEP_B1X;
      end
      iirdf2t_pkg::ST_SAT: begin
        if ((step_q == iirdf2t_pkg::STEP_A1Y) && (iirdf2t_pkg::EFF_ORDER > 1)) begin
          state_d = iirdf2t_pkg::ST_MUL;
          step_d  = iirdf2t_pkg::STEP_B2X;
        end else begin
          state_d = iirdf2t_pkg::ST_FIN;
        end
      end
      iirdf2t_pkg::ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = iirdf2t_pkg::ST_IDLE;
        end
      end
      default: state_d = iirdf2t_pkg::ST_IDLE;
    endcase
  end

  // Handshake and multiplier strobes.
  always_comb begin
    in_ready_o = (state_q == iirdf2t_pkg::ST_IDLE);
    mul_start  = (state_d == iirdf2t_pkg::ST_MUL) &&
                 !((state_q == iirdf2t_pkg::ST_MUL) && !mul_rsp.done);
    load_out   = (state_q == iirdf2t_pkg::ST_FIN) && (!out_valid_q || out_ready_i);
  end

  assign in_fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iirdf2t_pkg::ST_IDLE;
      step_q  <= iirdf2t_pkg::STEP_B0X;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Multiplier operands. The sample comes straight from the port on the accept cycle, since
  // x_q is only loaded at that edge; the feedback products take the saturated output y.
  // ---------------------------------------------------------------------------------------
  assign op_is_y = (step_d == iirdf2t_pkg::STEP_A1Y) || (step_d == iirdf2t_pkg::STEP_A2Y);

  always_comb begin
    mul_req.start   = mul_start;
    mul_req.coef    = coef_q[iirdf2t_pkg::coef_of_step(step_d)];
    if (op_is_y) begin
      mul_req.operand = y_q;
    end else if (state_q == iirdf2t_pkg::ST_IDLE) begin
      mul_req.operand = in_item_i.sample_in;
    end else begin
      mul_req.operand = x_q;
    end
  end

  iirdf2t_dsmul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // ---------------------------------------------------------------------------------------
  // Accumulator. All terms are Q29, so no alignment is needed; 42 bits hold the sum of a
  // 40-bit delay word and two 34-bit products without wrapping.
  // ---------------------------------------------------------------------------------------
  assign prod_ext = ACC_W'(mul_rsp.product);
  assign dly0_ext = ACC_W'(dly_q[0]);
  assign dly1_ext = ACC_W'(dly_q[1]);

  always_comb begin
    acc_d = acc_q;
    case (step_q)
      iirdf2t_pkg::STEP_B0X: acc_d = dly0_ext + prod_ext;
      iirdf2t_pkg::STEP_B1X: acc_d = (iirdf2t_pkg::EFF_ORDER > 1) ? (dly1_ext + prod_ext)
                                                                  : prod_ext;
      iirdf2t_pkg::STEP_A1Y: acc_d = acc_q - prod_ext;
      iirdf2t_pkg::STEP_B2X: acc_d = prod_ext;
      iirdf2t_pkg::STEP_A2Y: acc_d = acc_q - prod_ext;
      default:               acc_d = acc_q;
    endcase
  end

  // Q29 to Q15 with round half up, then saturation of the output to 16 bits.
  assign rnd    = acc_q + ROUND_BIAS_EXT;
  assign y_wide = rnd[ACC_W-1:iirdf2t_pkg::FRAC_SHIFT];
  assign y_fits = (&y_wide[RW-1:SW-1]) || !(|y_wide[RW-1:SW-1]);
  assign y_sat  = y_fits ? $signed(y_wide[SW-1:0])
                         : (y_wide[RW-1] ? iirdf2t_pkg::SAMPLE_MIN : iirdf2t_pkg::SAMPLE_MAX);

  // Saturation of an updated delay word to the signed 40-bit range.
  assign acc_fits = (&acc_q[ACC_W-1:DELAY_W-1]) || !(|acc_q[ACC_W-1:DELAY_W-1]);
  assign dly_sat  = acc_fits ? $signed(acc_q[DELAY_W-1:0])
                             : (acc_q[ACC_W-1] ? iirdf2t_pkg::DELAY_MIN : iirdf2t_pkg::DELAY_MAX);

  // Delay words are state and reset to zero; a start flag clears them as the item is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_q[0] <= '0;
      dly_q[1] <= '0;
    end else if (in_fire && in_item_i.start_block) begin
      dly_q[0] <= '0;
      dly_q[1] <= '0;
    end else if (state_q == iirdf2t_pkg::ST_SAT) begin
      if (step_q == iirdf2t_pkg::STEP_A1Y) begin
        dly_q[0] <= dly_sat;
      end else begin
        dly_q[1] <= dly_sat;
      end
    end
  end

  // Working registers of the item in flight.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q <= in_item_i.sample_in;
    end
    if ((state_q == iirdf2t_pkg::ST_MUL) && mul_rsp.done) begin
      acc_q <= acc_d;
    end
    if (state_q == iirdf2t_pkg::ST_ROUND) begin
      y_q    <= y_sat;
      clip_q <= !y_fits;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Output register. A finished item waits here while the next item is already accepted;
  // the sequencer only holds in its final state if the previous result is still untaken.
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.sample_out   <= y_q;
      out_q.clipped      <= clip_q;
      out_q.delay_first  <= dly_q[0];
      out_q.delay_second <= dly_q[1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for the DF-II transposed IIR filter: directed table, then random phases.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iirdf2t_pkg::*;

  // One item is in flight at a time, so the tail wait after the last result only needs to
  // cover one pass through the datapath.
  localparam int LATENCY         = 11 * EFF_ORDER + 7;
  // The slowest correct run is roughly 1400 items, each with the worst receiver stall and
  // sender gap, plus the long hold-off. The limit is several times that.
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_CYCLES     = 400;
  localparam int NUM_PHASES      = 9;
  localparam int ITEMS_PER_PHASE = 150;

  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  // Indexes past the last coefficient; the block must ignore writes to them.
  localparam logic [REG_IDX_W-1:0] REG_SPARE_FIRST = REG_IDX_W'(NUM_REGS);
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LAST  = '1;

  // One row of the directed part: either a coefficient write or a sample. Where the expected
  // output can be read straight off the arithmetic, it is typed in the row.
  typedef struct {
    bit                    is_cfg;
    logic [REG_IDX_W-1:0]  idx;
    logic [COEF_W-1:0]     data;
    in_item_t              item;
    bit                    typed;
    out_item_t             want;
  } dir_row_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_item_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_item_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [REG_IDX_W-1:0]  cfg_index_i = '0;
  logic [COEF_W-1:0]     cfg_data_i  = '0;

  // The testbench's own copy of the coefficients and the two delay words.
  logic signed [COEF_W-1:0] coef_reg [NUM_REGS];
  longint                   delay_word [2];

  // Outputs predicted for accepted items, oldest first.
  out_item_t awaited_outputs [$];

  int  errors        = 0;
  int  items_sent    = 0;
  int  results_seen  = 0;
  int  clipped_seen  = 0;
  int  settings_used = 0;
  int  burst_left    = 0;
  int  cycle_count   = 0;
  logic hold_req     = 1'b0;
  bit  hold_done     = 1'b0;

  iir_filter_df2t i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Computes the filter output for one sample and advances the delay words. Everything is
  // held in 64-bit integers, which is wide enough for every product and sum of the block.
  function automatic out_item_t filter_sample(input in_item_t item);
    longint    x, y, acc, v;
    longint    ff [3];
    longint    fb [3];
    longint    s_next [2];
    int        k;
    out_item_t res;
    x     = longint'(item.sample_in);
    ff[0] = longint'(coef_reg[REG_B0]);
    ff[1] = longint'(coef_reg[REG_B1]);
    ff[2] = longint'(coef_reg[REG_B2]);
    fb[0] = 0;
    fb[1] = longint'(coef_reg[REG_A1]);
    fb[2] = longint'(coef_reg[REG_A2]);
    if (item.start_block) begin
      delay_word[0] = 0;
      delay_word[1] = 0;
    end
    // Q29 sum to Q15, rounding half up, then saturate to 16 bits.
    acc = ff[0] * x + delay_word[0];
    y   = (acc + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
    res.clipped = 1'b0;
    if (y > SAMPLE_MAX) begin
      y = SAMPLE_MAX;
      res.clipped = 1'b1;
    end else if (y < SAMPLE_MIN) begin
      y = SAMPLE_MIN;
      res.clipped = 1'b1;
    end
    // The feedback uses the saturated output; the top delay word has no older word to add.
    s_next[0] = 0;
    s_next[1] = 0;
    for (k = 0; k < EFF_ORDER; k++) begin
      v = ff[k+1] * x - fb[k+1] * y;
      if (k + 1 < EFF_ORDER) v += delay_word[k+1];
      if (v > DELAY_MAX) v = DELAY_MAX;
      else if (v < DELAY_MIN) v = DELAY_MIN;
      s_next[k] = v;
    end
    delay_word[0]    = s_next[0];
    delay_word[1]    = s_next[1];
    res.sample_out   = y[SAMPLE_W-1:0];
    res.delay_first  = s_next[0][DELAY_W-1:0];
    res.delay_second = s_next[1][DELAY_W-1:0];
    return res;
  endfunction

  function automatic dir_row_t row_write(input logic [REG_IDX_W-1:0] idx,
                                         input logic [COEF_W-1:0] data);
    dir_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    return row;
  endfunction

  function automatic dir_row_t row_sample(input logic signed [SAMPLE_W-1:0] x,
                                          input bit start);
    dir_row_t row;
    row                  = '{default: '0};
    row.item.sample_in   = x;
    row.item.start_block = start;
    return row;
  endfunction

  // A sample whose output is known by inspection; in every such row the delay words stay zero.
  function automatic dir_row_t row_known(input logic signed [SAMPLE_W-1:0] x, input bit start,
                                         input logic signed [SAMPLE_W-1:0] y, input bit clip);
    dir_row_t row;
    row                   = row_sample(x, start);
    row.typed             = 1'b1;
    row.want.sample_out   = y;
    row.want.clipped      = clip;
    row.want.delay_first  = '0;
    row.want.delay_second = '0;
    return row;
  endfunction

  // Offers one item, with a random gap whenever a burst runs out. Valid is not lowered on
  // return, so a following item in the same burst goes out back to back.
  task automatic send_sample(input in_item_t item, input bit typed, input out_item_t want);
    int        gap;
    out_item_t pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_item_i  <= item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pred = filter_sample(item);
    awaited_outputs.push_back(typed ? want : pred);
    items_sent++;
  endtask

  // Coefficients only change while the block is idle: no item offered, every output received
  // and the input ready again. The idle test is made on the falling edge, clear of the
  // monitor's activity on the rising one.
  task automatic write_coef(input logic [REG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (awaited_outputs.size() != 0 || !in_ready_o);
    @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx < NUM_REGS) coef_reg[idx] = data;
  endtask

  task automatic compare_result(input out_item_t got);
    out_item_t want;
    results_seen++;
    if (got.clipped) clipped_seen++;
    if (awaited_outputs.size() == 0) begin
      $error("output with no item outstanding: sample_out %0d", got.sample_out);
      errors++;
    end else begin
      want = awaited_outputs.pop_front();
      if (got.sample_out !== want.sample_out) begin
        $error("sample_out: expected %0d, got %0d", want.sample_out, got.sample_out);
        errors++;
      end
      if (got.clipped !== want.clipped) begin
        $error("clipped: expected %0d, got %0d", want.clipped, got.clipped);
        errors++;
      end
      if (got.delay_first !== want.delay_first) begin
        $error("delay_first: expected %0d, got %0d", want.delay_first, got.delay_first);
        errors++;
      end
      if (got.delay_second !== want.delay_second) begin
        $error("delay_second: expected %0d, got %0d", want.delay_second, got.delay_second);
        errors++;
      end
    end
  endtask

  // Output monitor: every accepted output is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) compare_result(out_item_o);
  end

  // Receiver: alternates between always ready, random readiness and a sparse ready pattern,
  // in spans of random length. Once asked, it holds off for a long stretch so that the result
  // register stays full and the input side has to wait.
  initial begin : receiver
    int mode;
    int span;
    int every;
    int i;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
      mode  = $urandom_range(0, 2);
      span  = $urandom_range(20, 200);
      every = $urandom_range(2, 16);
      for (i = 0; i < span; i++) begin
        case (mode)
          0: begin
            out_ready_i <= 1'b1;
          end
          1: begin
            out_ready_i <= 1'($urandom_range(0, 1));
          end
          default: begin
            out_ready_i <= (i % every == 0);
          end
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Watchdog: a run that hangs is ended and reported as failing.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    dir_row_t             directed_rows [$];
    in_item_t             item;
    out_item_t            none;
    int                   phase;
    int                   n;
    int                   kind;
    int                   blk_left;
    int                   r;
    int                   directed_items;
    logic [COEF_W-1:0]    val;
    logic [REG_IDX_W-1:0] ridx;

    // The predictor starts from the reset state: b0 is one, everything else zero.
    foreach (coef_reg[i]) coef_reg[i] = '0;
    coef_reg[REG_B0] = COEF_B0_RST;
    delay_word[0]    = 0;
    delay_word[1]    = 0;
    none             = '0;

    // With the reset coefficients the filter is a plain pass-through.
    directed_rows.push_back(row_known(SAMPLE_MAX, 1'b1, SAMPLE_MAX, 1'b0));
    directed_rows.push_back(row_known(SAMPLE_MIN, 1'b0, SAMPLE_MIN, 1'b0));
    directed_rows.push_back(row_known(0, 1'b0, 0, 1'b0));
    directed_rows.push_back(row_known(-1, 1'b0, -1, 1'b0));
    // With b0 at its smallest step, the output shows the rounding directly: exactly half
    // rounds upwards, on both sides of zero.
    directed_rows.push_back(row_write(REG_B0, 1));
    directed_rows.push_back(row_known(8192, 1'b0, 1, 1'b0));
    directed_rows.push_back(row_known(-8192, 1'b0, 0, 1'b0));
    directed_rows.push_back(row_known(8191, 1'b0, 0, 1'b0));
    directed_rows.push_back(row_known(-8193, 1'b0, -1, 1'b0));
    // Largest and most negative gains drive the output into saturation.
    directed_rows.push_back(row_write(REG_B0, COEF_MAX));
    directed_rows.push_back(row_known(SAMPLE_MAX, 1'b0, SAMPLE_MAX, 1'b1));
    directed_rows.push_back(row_known(SAMPLE_MIN, 1'b0, SAMPLE_MIN, 1'b1));
    directed_rows.push_back(row_write(REG_B0, COEF_MIN));
    directed_rows.push_back(row_known(SAMPLE_MAX, 1'b0, SAMPLE_MIN, 1'b1));
    directed_rows.push_back(row_known(SAMPLE_MIN, 1'b0, SAMPLE_MAX, 1'b1));
    // Writes past the last register must leave b0 at minus eight, so a sample of one gives exactly minus 8.
    directed_rows.push_back(row_write(REG_SPARE_FIRST, '1));
    directed_rows.push_back(row_write(REG_SPARE_LAST, '0));
    directed_rows.push_back(row_known(1, 1'b0, -8, 1'b0));
    // b0 back at one and every other coefficient at an extreme, with the feedback path fully exercised.
    directed_rows.push_back(row_write(REG_B0, COEF_B0_RST));
    directed_rows.push_back(row_write(REG_B1, COEF_MAX));
    directed_rows.push_back(row_write(REG_B2, COEF_MIN));
    directed_rows.push_back(row_write(REG_A1, COEF_MIN));
    directed_rows.push_back(row_write(REG_A2, COEF_MAX));
    directed_rows.push_back(row_sample(SAMPLE_MAX, 1'b1));
    directed_rows.push_back(row_sample(SAMPLE_MIN, 1'b0));
    directed_rows.push_back(row_sample(12345, 1'b0));
    directed_rows.push_back(row_sample(0, 1'b0));
    directed_rows.push_back(row_sample(SAMPLE_MIN, 1'b1));
    // A gentle second-order low-pass: step response, a reversal, and a restart mid-stream.
    directed_rows.push_back(row_write(REG_B0, 1106));
    directed_rows.push_back(row_write(REG_B1, 2212));
    directed_rows.push_back(row_write(REG_B2, 1106));
    directed_rows.push_back(row_write(REG_A1, -18727));
    directed_rows.push_back(row_write(REG_A2, 6763));
    directed_rows.push_back(row_sample(16000, 1'b1));
    directed_rows.push_back(row_sample(16000, 1'b0));
    directed_rows.push_back(row_sample(16000, 1'b0));
    directed_rows.push_back(row_sample(-16000, 1'b0));
    directed_rows.push_back(row_sample(16000, 1'b1));
    directed_rows.push_back(row_sample(SAMPLE_MAX, 1'b0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_coef(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_sample(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end
    end
    directed_items = items_sent;
    settings_used  = 5;

    // Random phases. The first uses extreme coefficients and the second fully random ones;
    // later phases pick among random, extreme, moderate and pass-through settings.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      kind = (phase == 0) ? 1 : ((phase == 1) ? 0 : $urandom_range(0, 3));
      for (r = 0; r < NUM_REGS; r++) begin
        case (kind)
          0: begin
            val = COEF_W'($urandom);
          end
          1: begin
            case ($urandom_range(0, 4))
              0:       val = COEF_MAX;
              1:       val = COEF_MIN;
              2:       val = '0;
              3:       val = COEF_W'(1);
              default: val = '1;
            endcase
          end
          2: begin
            val = (r < REG_A1) ? COEF_W'($urandom_range(0, 16383) - 8192)
                               : COEF_W'($urandom_range(0, 32767) - 16384);
          end
          default: begin
            val = (r == REG_B0) ? COEF_B0_RST : '0;
          end
        endcase
        ridx = REG_IDX_W'(r);
        write_coef(ridx, val);
      end
      if ($urandom_range(0, 1)) begin
        ridx = REG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST));
        write_coef(ridx, COEF_W'($urandom));
      end
      settings_used++;

      // Samples arrive in blocks that begin with a restart, with the odd stray restart inside
      // a block. Most samples span the full range, some sit at the rails, some are tiny.
      blk_left = 0;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 2 && n == 20) hold_req <= 1'b1;
        if (blk_left == 0) begin
          blk_left         = $urandom_range(1, 40);
          item.start_block = 1'b1;
        end else begin
          item.start_block = ($urandom_range(0, 19) == 0);
        end
        blk_left--;
        case ($urandom_range(0, 9))
          0:       item.sample_in = SAMPLE_MAX;
          1:       item.sample_in = SAMPLE_MIN;
          2, 3:    item.sample_in = SAMPLE_W'($urandom_range(0, 512) - 256);
          default: item.sample_in = SAMPLE_W'($urandom);
        endcase
        send_sample(item, 1'b0, none);
      end
    end

    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (awaited_outputs.size() != 0);
    repeat (LATENCY) @(posedge clk_i);

    $display("Run covered %0d items (%0d directed) over %0d coefficient settings.",
             items_sent, directed_items, settings_used);
    $display("%0d outputs were checked, %0d of them saturated.", results_seen, clipped_seen);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
